### src/recentering_array_deque_assert.svh
// Assertion macros shared by the deque checkers.
`ifndef RECENTERING_ARRAY_DEQUE_ASSERT_SVH
`define RECENTERING_ARRAY_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define RAD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define RAD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/rad_pkg.sv
// Types, sizes and codes shared by the recentering deque modules.
package rad_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int POS_W      = $clog2(DEPTH + 1);
   localparam int DIST_W     = POS_W + 1;
   localparam int VALUE_W    = 32;
   localparam int FILL_W     = 5;
   localparam int CENTER     = DEPTH / 2;

   typedef enum logic [1:0] {
      KIND_PUSH_LEFT  = 2'd0,
      KIND_PUSH_RIGHT = 2'd1,
      KIND_POP_LEFT   = 2'd2,
      KIND_POP_RIGHT  = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_EMPTY = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SHIFT = 3'b010,
      ST_STORE = 3'b100
   } state_type;

   typedef struct packed {
      kind_type                   kind;
      logic signed [VALUE_W-1:0]  push_value;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0]  pop_value;
      status_type                 status;
      logic [FILL_W-1:0]          fill_count;
   } rsp_type;

   // Per-cell control: load from a neighbor or take the write data.
   typedef struct packed {
      logic shift_left;
      logic shift_right;
      logic write;
   } cell_ctrl_type;

   // Command from the sequencer to the row of cells.
   typedef struct packed {
      logic             shift_left;
      logic             shift_right;
      logic             write_en;
      logic [IDX_W-1:0] write_idx;
   } chain_cmd_type;

endpackage

### src/recentering_array_deque.sv
// Top level of the recentering deque: sequencer, window state and result register.
//
//   channel   ports                      handshake
//   request   start, busy, req_item      taken when start is high and busy is low
//   response  rsp_valid, rsp_item        one-cycle strobe, no backpressure
//
// A plain push or pop is taken with no busy state; its response follows in the next
// cycle and busy stays low, so requests may arrive every cycle.
// A push that meets its array end walks the row of cells one slot per cycle: busy
// stays high while the sequencer walks dist slots in ST_SHIFT and then stores in ST_STORE,
// dist = ceil(free space on the far side / 2), at most ceil(DEPTH / 2).
// Reset leaves the deque empty with the window at the center; cell
// contents stay unset until written.
module recentering_array_deque
   import rad_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_item,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   state_type             state_ff, state_in;
   logic [POS_W-1:0]      left_pos_ff, left_pos_in;
   logic [POS_W-1:0]      count_ff, count_in;
   logic [POS_W-1:0]      dist_ff, dist_in;
   kind_type              held_kind_ff, held_kind_in;
   logic [DATA_WIDTH-1:0] held_value_ff, held_value_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;

   chain_cmd_type         chain_cmd;
   logic [DATA_WIDTH-1:0] write_data;
   logic [IDX_W-1:0]      read_idx;
   logic [DATA_WIDTH-1:0] read_data;

   logic                  is_full;
   logic                  is_empty;
   logic                  at_right_end;
   logic [DIST_W-1:0]     free_plus;
   logic [DIST_W-1:0]     left_plus;
   logic [POS_W-1:0]      right_dist;
   logic [POS_W-1:0]      left_dist;
   logic [POS_W-1:0]      count_inc;
   logic [POS_W-1:0]      count_dec;
   logic [POS_W-1:0]      right_slot;

   // Window bookkeeping.
   always_comb begin
      is_full      = (count_ff == POS_W'(DEPTH));
      is_empty     = (count_ff == '0);
      at_right_end = (DIST_W'(left_pos_ff) + DIST_W'(count_ff)) >= DIST_W'(DEPTH);
      free_plus    = DIST_W'(DEPTH) - DIST_W'(count_ff) + DIST_W'(1);
      left_plus    = DIST_W'(left_pos_ff) + DIST_W'(1);
      right_dist   = POS_W'(free_plus >> 1);
      left_dist    = POS_W'(left_plus >> 1);
      count_inc    = count_ff + POS_W'(1);
      count_dec    = count_ff - POS_W'(1);
      right_slot   = left_pos_ff + count_ff;
   end

   // Address the popped end of the window.
   always_comb begin
      if (req_item.kind == KIND_POP_LEFT) begin
         read_idx = IDX_W'(left_pos_ff);
      end else begin
         read_idx = IDX_W'(right_slot - POS_W'(1));
      end
   end

   // Sequence requests, recentering walks and stores.
   always_comb begin
      state_in      = state_ff;
      left_pos_in   = left_pos_ff;
      count_in      = count_ff;
      dist_in       = dist_ff;
      held_kind_in  = held_kind_ff;
      held_value_in = held_value_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      chain_cmd     = '0;
      write_data    = held_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               rsp_in.pop_value = '0;
               rsp_in.status    = STATUS_OK;
               write_data       = DATA_WIDTH'(req_item.push_value);
               unique case (req_item.kind)
                  KIND_PUSH_LEFT: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else if (left_pos_ff == '0) begin
                        held_kind_in  = req_item.kind;
                        held_value_in = DATA_WIDTH'(req_item.push_value);
                        dist_in       = right_dist;
                        state_in      = ST_SHIFT;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        chain_cmd.write_en  = 1'b1;
                        chain_cmd.write_idx = IDX_W'(left_pos_ff - POS_W'(1));
                        left_pos_in         = left_pos_ff - POS_W'(1);
                        count_in            = count_inc;
                     end
                  end
                  KIND_PUSH_RIGHT: begin
                     if (is_full) begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = STATUS_FULL;
                     end else if (at_right_end) begin
                        held_kind_in  = req_item.kind;
                        held_value_in = DATA_WIDTH'(req_item.push_value);
                        dist_in       = left_dist;
                        state_in      = ST_SHIFT;
                     end else begin
                        rsp_valid_in        = 1'b1;
                        chain_cmd.write_en  = 1'b1;
                        chain_cmd.write_idx = IDX_W'(right_slot);
                        count_in            = count_inc;
                     end
                  end
                  KIND_POP_LEFT,
                  KIND_POP_RIGHT: begin
                     rsp_valid_in = 1'b1;
                     if (is_empty) begin
                        rsp_in.status = STATUS_EMPTY;
                        left_pos_in   = POS_W'(CENTER);
                     end else begin
                        rsp_in.pop_value = VALUE_W'(read_data);
                        count_in         = count_dec;
                        if (req_item.kind == KIND_POP_LEFT) begin
                           left_pos_in = left_pos_ff + POS_W'(1);
                        end
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b0;
                  end
               endcase
               rsp_in.fill_count = FILL_W'(count_in);
            end
         end

         ST_SHIFT: begin
            // Advance the window one slot away from the blocked end.
            if (held_kind_ff == KIND_PUSH_LEFT) begin
               chain_cmd.shift_right = 1'b1;
               left_pos_in           = left_pos_ff + POS_W'(1);
            end else begin
               chain_cmd.shift_left = 1'b1;
               left_pos_in          = left_pos_ff - POS_W'(1);
            end
            dist_in = dist_ff - POS_W'(1);
            if (dist_ff == POS_W'(1)) begin
               state_in = ST_STORE;
            end
         end

         ST_STORE: begin
            // Store the held push now that there is room at its end.
            chain_cmd.write_en = 1'b1;
            if (held_kind_ff == KIND_PUSH_LEFT) begin
               chain_cmd.write_idx = IDX_W'(left_pos_ff - POS_W'(1));
               left_pos_in         = left_pos_ff - POS_W'(1);
            end else begin
               chain_cmd.write_idx = IDX_W'(right_slot);
            end
            count_in          = count_inc;
            rsp_valid_in      = 1'b1;
            rsp_in.pop_value  = '0;
            rsp_in.status     = STATUS_OK;
            rsp_in.fill_count = FILL_W'(count_inc);
            state_in          = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   rad_chain u_chain (
      .clock      (clock),
      .chain_cmd  (chain_cmd),
      .write_data (write_data),
      .read_idx   (read_idx),
      .read_data  (read_data)
   );

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         left_pos_ff  <= POS_W'(CENTER);
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         left_pos_ff  <= left_pos_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Held request and response payload.
   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      held_kind_ff  <= held_kind_in;
      held_value_ff <= held_value_in;
      rsp_ff        <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### src/rad_cell.sv
// One storage cell of the deque row: holds a word and loads from a neighbor.
module rad_cell
   import rad_pkg::*;
(
   input  logic                  clock,
   input  cell_ctrl_type         cell_ctrl,
   input  logic [DATA_WIDTH-1:0] left_data,
   input  logic [DATA_WIDTH-1:0] right_data,
   input  logic [DATA_WIDTH-1:0] write_data,
   output logic [DATA_WIDTH-1:0] data_out
);

   logic [DATA_WIDTH-1:0] data_ff;
   logic [DATA_WIDTH-1:0] data_in;

   // Pick the next word: write, take from a neighbor, or hold.
   always_comb begin
      priority if (cell_ctrl.write) begin
         data_in = write_data;
      end else if (cell_ctrl.shift_right) begin
         data_in = left_data;
      end else if (cell_ctrl.shift_left) begin
         data_in = right_data;
      end else begin
         data_in = data_ff;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;

endmodule

### src/rad_chain.sv
// Row of deque cells with write decode and one read port.
module rad_chain
   import rad_pkg::*;
(
   input  logic                  clock,
   input  chain_cmd_type         chain_cmd,
   input  logic [DATA_WIDTH-1:0] write_data,
   input  logic [IDX_W-1:0]      read_idx,
   output logic [DATA_WIDTH-1:0] read_data
);

   logic [DATA_WIDTH-1:0] cell_data [DEPTH];

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         cell_ctrl_type         ctrl;
         logic [DATA_WIDTH-1:0] from_left;
         logic [DATA_WIDTH-1:0] from_right;

         // Decode the write slot and fan out the shift.
         assign ctrl.shift_left  = chain_cmd.shift_left;
         assign ctrl.shift_right = chain_cmd.shift_right;
         assign ctrl.write       = chain_cmd.write_en &&
                                   (chain_cmd.write_idx == IDX_W'(gi));

         if (gi == 0) begin : g_first
            assign from_left = '0;
         end else begin : g_inner_left
            assign from_left = cell_data[gi-1];
         end

         if (gi == DEPTH - 1) begin : g_last
            assign from_right = '0;
         end else begin : g_inner_right
            assign from_right = cell_data[gi+1];
         end

         rad_cell u_cell (
            .clock      (clock),
            .cell_ctrl  (ctrl),
            .left_data  (from_left),
            .right_data (from_right),
            .write_data (write_data),
            .data_out   (cell_data[gi])
         );
      end
   endgenerate

   // Read the word at the deque end being popped.
   assign read_data = cell_data[read_idx];

endmodule

### src/rad_checker.sv
// Port-level checks on the recentering deque, bound to the top level.
`include "recentering_array_deque_assert.svh"

module rad_checker
   import rad_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input req_type req_item,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_item
);

   `RAD_ASSERT_NEXT(a_request_answered, clock, reset, start && !busy, rsp_valid || busy, "request neither answered nor held busy")
   `RAD_ASSERT_NOW(a_fill_bounded, clock, reset, rsp_valid, rsp_item.fill_count <= FILL_W'(DEPTH), "fill count beyond depth")
   `RAD_ASSERT_NOW(a_empty_clean, clock, reset, rsp_valid && rsp_item.status == STATUS_EMPTY, rsp_item.fill_count == '0 && rsp_item.pop_value == '0, "empty pop with data or fill")
   `RAD_ASSERT_NOW(a_full_drop, clock, reset, rsp_valid && rsp_item.status == STATUS_FULL, rsp_item.fill_count == FILL_W'(DEPTH), "dropped push while not full")
   `RAD_ASSERT_NOW(a_response_sourced, clock, reset, rsp_valid, $past(busy) || $past(start), "response without a request")

endmodule

bind recentering_array_deque rad_checker u_rad_checker (.*);
